[rtl/igt_pkg.sv]
// ----------------------------------------------------------------------------
// igt_pkg: shared types and constants for the gene / TSS interval matcher
// Field widths, command and register codes, and the saturating increment.
// ----------------------------------------------------------------------------
package igt_pkg;

  localparam int POS_W       = 32;
  localparam int SLOT_W      = 12;
  localparam int OWNER_W     = 10;
  localparam int CMD_W       = 2;
  localparam int GENE_IDX_W  = 10;
  localparam int SPAN_W      = 13;
  localparam int CNT_W       = 32;
  localparam int GCOUNT_W    = 11;
  localparam int TCOUNT_W    = 13;
  localparam int CFG_ADDR_W  = 1;
  localparam int CFG_DATA_W  = 13;
  localparam int IN_DATA_W   = 88;
  localparam int OUT_DATA_W  = 88;

  // command codes carried in tuser
  localparam logic [CMD_W-1:0] CMD_LOAD_GENE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_TSS  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY     = 2'd2;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_GENE_COUNT = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_TSS_COUNT  = 1'd1;

  localparam logic [SPAN_W-1:0] SPAN_MAX = {SPAN_W{1'b1}};

  // inclusive position range
  typedef struct packed {
    logic [POS_W-1:0] hi;
    logic [POS_W-1:0] lo;
  } range_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
  endfunction

endpackage

[rtl/interval_gene_tss_match.sv]
// Load items are taken at once; s_tready stays high in idle.
// A query, once accepted, runs a gene scan up to the first overlapping slot, or over
// all gene_count slots with no overlap; on a match a TSS scan over tss_count slots follows,
// then the gene counter is read and updated and the result presented, else only the result is presented.
// Scans read one slot a cycle from each table, counts clamped to capacity; one item at a time.
// After rst all MAX_GENES gene counters are cleared, with s_tready low.
// ----------------------------------------------------------------------------
// interval_gene_tss_match: gene interval / TSS overlap search
// Gene and TSS tables in RAM, a sequencer that scans them through one shared
// range compare unit, saturating per-gene and chromosome counters.
// ----------------------------------------------------------------------------
module interval_gene_tss_match
  import igt_pkg::*;
#(
  parameter int MAX_GENES = 1024,
  parameter int MAX_TSS   = 4096
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // input items
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // s_tdata: slot[11:0], position_from[43:12], position_to[75:44],
  //          owner_gene[85:76], zero pad[87:86]
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // s_tuser: cmd[1:0]
  input  logic [CMD_W-1:0]      s_tuser,
  // result items
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // m_tdata: found[0], gene_index[10:1], span_count[23:11],
  //          gene_total[55:24], chrom_total[87:56]
  output logic [OUT_DATA_W-1:0] m_tdata
);

  localparam int GAW = (MAX_GENES > 1) ? $clog2(MAX_GENES) : 1;
  localparam int TAW = (MAX_TSS > 1) ? $clog2(MAX_TSS) : 1;
  localparam int GCW = $clog2(MAX_GENES + 1);
  localparam int TCW = $clog2(MAX_TSS + 1);
  localparam int IW  = (GAW > GENE_IDX_W) ? GAW : GENE_IDX_W;
  localparam int TSS_W = POS_W + OWNER_W;

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_GENE   = 3'd2;
  localparam logic [2:0] ST_TSS    = 3'd3;
  localparam logic [2:0] ST_CNT_RD = 3'd4;
  localparam logic [2:0] ST_CNT_WR = 3'd5;
  localparam logic [2:0] ST_OUT    = 3'd6;

  logic [2:0]            state;
  logic [GCOUNT_W-1:0]   gene_count;
  logic [TCOUNT_W-1:0]   tss_count;
  logic [GCW-1:0]        clr_idx;
  logic [GCW-1:0]        ng;
  logic [TCW-1:0]        nt;
  logic [GCW-1:0]        gidx;
  logic [TCW-1:0]        tidx;
  logic                  pend_v;
  logic [GAW-1:0]        pend_gidx;
  logic [GAW-1:0]        hit;
  logic                  found;
  logic [SPAN_W-1:0]     span;
  logic [CNT_W-1:0]      gene_total;
  logic [CNT_W-1:0]      chrom_total;
  range_t                query;
  logic                  out_load;

  // input field split
  logic [SLOT_W-1:0]     in_slot;
  logic [POS_W-1:0]      in_from;
  logic [POS_W-1:0]      in_to;
  logic [OWNER_W-1:0]    in_owner;
  logic [31:0]           slot_ext;
  logic                  accept;

  assign in_slot  = s_tdata[11:0];
  assign in_from  = s_tdata[43:12];
  assign in_to    = s_tdata[75:44];
  assign in_owner = s_tdata[85:76];
  assign slot_ext = 32'(in_slot);
  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  // gene table: {end, start}
  logic                  gene_we;
  logic [2*POS_W-1:0]    gene_rdata;
  range_t                gene_rng;

  assign gene_we = accept && (s_tuser == CMD_LOAD_GENE) && (slot_ext < 32'(MAX_GENES));
  assign gene_rng = gene_rdata;

  igt_ram #(.WIDTH(2 * POS_W), .DEPTH(MAX_GENES)) u_gene_ram (
    .clk   (clk),
    .we    (gene_we),
    .waddr (slot_ext[GAW-1:0]),
    .wdata ({in_to, in_from}),
    .raddr (gidx[GAW-1:0]),
    .rdata (gene_rdata)
  );

  // TSS table: {owner, position}
  logic                  tss_we;
  logic [TSS_W-1:0]      tss_rdata;
  logic [POS_W-1:0]      tss_pos;
  logic [IW-1:0]         tss_owner_ext;
  logic [IW-1:0]         hit_ext;

  assign tss_we = accept && (s_tuser == CMD_LOAD_TSS) && (slot_ext < 32'(MAX_TSS));
  assign tss_pos       = tss_rdata[POS_W-1:0];
  assign tss_owner_ext = IW'(tss_rdata[TSS_W-1:POS_W]);
  assign hit_ext       = IW'(hit);

  igt_ram #(.WIDTH(TSS_W), .DEPTH(MAX_TSS)) u_tss_ram (
    .clk   (clk),
    .we    (tss_we),
    .waddr (slot_ext[TAW-1:0]),
    .wdata ({in_owner, in_from}),
    .raddr (tidx[TAW-1:0]),
    .rdata (tss_rdata)
  );

  // per-gene counters: cleared by the sweep after reset
  logic                  cnt_we;
  logic [GAW-1:0]        cnt_waddr;
  logic [CNT_W-1:0]      cnt_wdata;
  logic [CNT_W-1:0]      cnt_rdata;
  logic [CNT_W-1:0]      cnt_inc;

  assign cnt_inc   = sat_inc(cnt_rdata);
  assign cnt_we    = (state == ST_CLEAR) || (state == ST_CNT_WR);
  assign cnt_waddr = (state == ST_CLEAR) ? clr_idx[GAW-1:0] : hit;
  assign cnt_wdata = (state == ST_CLEAR) ? '0 : cnt_inc;

  igt_ram #(.WIDTH(CNT_W), .DEPTH(MAX_GENES)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (hit),
    .rdata (cnt_rdata)
  );

  // shared compare: gene interval in gene scan, single TSS point otherwise
  range_t probe;
  logic   overlap;

  always_comb begin
    if (state == ST_GENE) begin
      probe = gene_rng;
    end else begin
      probe.lo = tss_pos;
      probe.hi = tss_pos;
    end
  end

  igt_range_cmp u_cmp (
    .query   (query),
    .probe   (probe),
    .overlap (overlap)
  );

  // clamped scan lengths
  logic [GCW-1:0] ng_next;
  logic [TCW-1:0] nt_next;

  always_comb begin
    if (32'(gene_count) < 32'(MAX_GENES)) begin
      ng_next = GCW'(gene_count);
    end else begin
      ng_next = GCW'(MAX_GENES);
    end
    if (32'(tss_count) < 32'(MAX_TSS)) begin
      nt_next = TCW'(tss_count);
    end else begin
      nt_next = TCW'(MAX_TSS);
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gene_count <= '0;
      tss_count  <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_GENE_COUNT: gene_count <= cfg_data[GCOUNT_W-1:0];
        REG_TSS_COUNT:  tss_count  <= cfg_data[TCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // result register loads once the previous item is gone or leaving
  assign out_load = (state == ST_OUT) && (!m_tvalid || m_tready);

  // result valid: set on load, cleared when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      clr_idx     <= '0;
      pend_v      <= 1'b0;
      chrom_total <= '0;
    end else begin
      case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == GCW'(MAX_GENES - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept && (s_tuser == CMD_QUERY)) begin
            query.lo   <= in_from;
            query.hi   <= in_to;
            ng         <= ng_next;
            nt         <= nt_next;
            gidx       <= '0;
            pend_v     <= 1'b0;
            hit        <= '0;
            found      <= 1'b0;
            span       <= '0;
            gene_total <= '0;
            state      <= ST_GENE;
          end
        end
        ST_GENE: begin
          // one read issued per cycle, compared the cycle after
          if (pend_v && overlap) begin
            hit    <= pend_gidx;
            found  <= 1'b1;
            tidx   <= '0;
            pend_v <= 1'b0;
            state  <= ST_TSS;
          end else if (!pend_v && (gidx >= ng)) begin
            state <= ST_OUT;
          end else begin
            pend_v    <= (gidx < ng);
            pend_gidx <= gidx[GAW-1:0];
            if (gidx < ng) begin
              gidx <= gidx + 1'b1;
            end
          end
        end
        ST_TSS: begin
          if (pend_v && overlap && (tss_owner_ext == hit_ext) && (span != SPAN_MAX)) begin
            span <= span + 1'b1;
          end
          if (!pend_v && (tidx >= nt)) begin
            state <= ST_CNT_RD;
          end else begin
            pend_v <= (tidx < nt);
            if (tidx < nt) begin
              tidx <= tidx + 1'b1;
            end
          end
        end
        ST_CNT_RD: begin
          state <= ST_CNT_WR;
        end
        ST_CNT_WR: begin
          gene_total <= cnt_inc;
          state      <= ST_OUT;
        end
        ST_OUT: begin
          // wait for the output register to free up
          if (out_load) begin
            chrom_total <= sat_inc(chrom_total);
            m_tdata     <= {sat_inc(chrom_total), gene_total, span,
                            hit_ext[GENE_IDX_W-1:0], found};
            state       <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

[rtl/igt_ram.sv]
// ----------------------------------------------------------------------------
// igt_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module igt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/igt_range_cmp.sv]
// ----------------------------------------------------------------------------
// igt_range_cmp: shared range compare unit
// Flags whether a probe range overlaps the query range (both inclusive).
// A single point is checked by giving it as a range of one position.
// ----------------------------------------------------------------------------
module igt_range_cmp
  import igt_pkg::*;
(
  input  range_t query,
  input  range_t probe,
  output logic   overlap
);

  // overlap unless one range lies wholly past the other
  assign overlap = (query.lo <= probe.hi) && (probe.lo <= query.hi);

endmodule

[rtl/igt_checker.sv]
// ----------------------------------------------------------------------------
// igt_checker: port-level checks for interval_gene_tss_match
// Watches the stream ports over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
module igt_checker
  import igt_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic [CMD_W-1:0]      s_tuser,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata
);

  // a stalled result holds its value
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // a query keeps the block busy for at least the next cycle
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == CMD_QUERY) |=> !s_tready)
    else $error("input taken right after a query");

  // no match means zero index, span and gene total
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> (m_tdata[55:1] == '0))
    else $error("fields set on a result with no match");

  // every result has counted at least its own query
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[87:56] != '0))
    else $error("chromosome total is zero on a result");

  // reset drops any pending result
  assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

endmodule

bind interval_gene_tss_match igt_checker u_igt_checker (.*);
